FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define SAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle brings an expression true in the next.
`define SAC_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);

`endif

FILE: hdl/sac_pkg.sv
package sac_pkg;

  localparam int ADDR_BITS      = 16;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_SETS       = 64;
  localparam int DEF_LINE_BYTES = 64;
  localparam int STAMP_W        = 64;
  localparam int TALLY_W        = 64;

  localparam logic       OP_WRITE      = 1'b1;
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
  localparam logic [1:0] STAT_PAST_END = 2'd2;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  typedef struct packed {
    logic                 op;
    logic [ADDR_BITS-1:0] address;
    logic [2:0]           size_bytes;
    logic [31:0]          write_data;
  } sac_req_t;

  typedef struct packed {
    logic [31:0]        read_data;
    logic [1:0]         status;
    logic [1:0]         access_hits;
    logic [1:0]         access_misses;
    logic [1:0]         access_writebacks;
    logic [TALLY_W-1:0] total_hits;
    logic [TALLY_W-1:0] total_misses;
    logic [TALLY_W-1:0] total_dirty_misses;
  } sac_rsp_t;

endpackage

FILE: hdl/sac_ram.sv
module sac_ram
  import sac_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  // Read-first: a read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/set_assoc_lru_writeback_cache.sv
// Channel | Ports                          | Direction | Moves
// request | in_valid, in_stall, in_data    | in        | one access (op, address, size, data)
// result  | out_valid, out_stall, out_data | out       | one result per request
//
// One request at a time. Accepting a request and posting its result are registered steps;
// in between come a line lookup for each line touched, then a write or a read of each byte.
// A miss adds an LRU stamp scan over the WAYS ways when no way is free, a line fill and,
// for a dirty victim, a write-back first; the byte-wide memories move one byte at a time.
// After reset a clearing pass zeroes backing memory and tag rows; in_stall stays high
// during it. A finished result waits in the output register while the next request is
// taken; out_stall holds it.
`include "assert_macros.svh"

module set_assoc_lru_writeback_cache
  import sac_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sac_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sac_rsp_t out_data
);

  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int SET_W      = $clog2(SETS);
  localparam int SIW        = (SET_W == 0) ? 1 : SET_W;
  localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WC_W       = $clog2(WAYS + 1);
  localparam int TAG_W      = ADDR_BITS - OFF_W - SET_W;
  localparam int ROW_W      = WAYS * (2 + TAG_W + STAMP_W);
  localparam int DATA_DEPTH = SETS * WAYS * LINE_BYTES;
  localparam int DA_W       = $clog2(DATA_DEPTH);
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;

  typedef enum logic [9:0] {
    ST_CLEAR   = 10'b0000000001,
    ST_IDLE    = 10'b0000000010,
    ST_LOOK    = 10'b0000000100,
    ST_SCAN    = 10'b0000001000,
    ST_WB      = 10'b0000010000,
    ST_FILL    = 10'b0000100000,
    ST_BYTE    = 10'b0001000000,
    ST_BYTE_RD = 10'b0010000000,
    ST_NEXT    = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } sac_state_t;

  function automatic logic [SIW-1:0] set_of(input logic [ADDR_BITS-1:0] a);
    return SIW'(a >> OFF_W) & SIW'(SETS - 1);
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_BITS-1:0] a);
    return TAG_W'(a >> (OFF_W + SET_W));
  endfunction

  function automatic logic [DA_W-1:0] slot_addr(input logic [SIW-1:0] s,
                                                input logic [WAY_W-1:0] w,
                                                input logic [OFF_W-1:0] o);
    return DA_W'((int'(s) * WAYS + int'(w)) * LINE_BYTES + int'(o));
  endfunction

  function automatic logic [ADDR_BITS-1:0] line_addr(input logic [TAG_W-1:0] t,
                                                     input logic [SIW-1:0] s,
                                                     input logic [OFF_W-1:0] o);
    return (ADDR_BITS'(t) << (OFF_W + SET_W)) | (ADDR_BITS'(s) << OFF_W) | ADDR_BITS'(o);
  endfunction

  sac_state_t st_r, st_nxt;
  sac_req_t   req_r;
  logic [1:0]           bi_r;
  logic [WAY_W-1:0]     way_r;
  logic [WC_W-1:0]      scan_r;
  logic [OFF_W:0]       cnt_r;
  logic [ADDR_BITS-1:0] clr_r;
  logic                 fwd_r;
  logic [STAMP_W-1:0]   use_ctr_r;
  logic [TALLY_W-1:0]   hit_tally_r, miss_tally_r, dirty_tally_r;
  logic [1:0]           acc_h_r, acc_m_r, acc_w_r, status_r;
  logic [31:0]          rdata_r;
  logic                 out_valid_r;
  sac_rsp_t             out_data_r;

  // Working copy of the tag row of the current set.
  logic [WAYS-1:0]                   row_v_r, row_d_r;
  logic [WAYS-1:0][TAG_W-1:0]        row_t_r;
  logic [WAYS-1:0][STAMP_W-1:0]      row_s_r;
  logic [WAYS-1:0]                   rd_v, rd_d, lk_v, lk_d;
  logic [WAYS-1:0][TAG_W-1:0]        rd_t, lk_t;
  logic [WAYS-1:0][STAMP_W-1:0]      rd_s, lk_s;

  logic [ROW_W-1:0]     tag_rdata, tag_wdata;
  logic [SIW-1:0]       tag_raddr, tag_waddr;
  logic                 tag_we;
  logic [DA_W-1:0]      dat_raddr, dat_waddr;
  logic [7:0]           dat_rdata, dat_wdata;
  logic                 dat_we;
  logic [ADDR_BITS-1:0] mem_raddr, mem_waddr;
  logic [7:0]           mem_rdata, mem_wdata;
  logic                 mem_we;

  logic [ADDR_BITS-1:0] cur_a, nxt_a;
  logic [SIW-1:0]       cur_set;
  logic [TAG_W-1:0]     cur_tag;
  logic [OFF_W-1:0]     cur_off, cnt_off, cnt_prev;
  logic [WAY_W-1:0]     hit_way, inv_way, scan_way;
  logic                 hit_any, inv_any;
  logic                 size_ok, past_end, last_byte;
  logic [ADDR_BITS:0]   end_sum;
  logic [STAMP_W-1:0]   use_inc;

  assign cur_a    = req_r.address + ADDR_BITS'(bi_r);
  assign nxt_a    = cur_a + ADDR_BITS'(1);
  assign cur_set  = set_of(cur_a);
  assign cur_tag  = tag_of(cur_a);
  assign cur_off  = cur_a[OFF_W-1:0];
  assign cnt_off  = cnt_r[OFF_W-1:0];
  assign cnt_prev = OFF_W'(cnt_r - (OFF_W+1)'(1));
  assign scan_way = scan_r[WAY_W-1:0];
  assign use_inc  = use_ctr_r + STAMP_W'(1);
  assign last_byte = ({1'b0, bi_r} + 3'd1) == req_r.size_bytes;

  assign size_ok  = (in_data.size_bytes == SIZE_BYTE) || (in_data.size_bytes == SIZE_HALF) ||
                    (in_data.size_bytes == SIZE_WORD);
  assign end_sum  = (ADDR_BITS+1)'(in_data.address) + (ADDR_BITS+1)'(in_data.size_bytes);
  assign past_end = end_sum[ADDR_BITS] && (end_sum[ADDR_BITS-1:0] != '0);

  assign {rd_v, rd_d, rd_t, rd_s} = tag_rdata;

  // Forward the working row when the new lookup hits the row written last cycle.
  assign lk_v = fwd_r ? row_v_r : rd_v;
  assign lk_d = fwd_r ? row_d_r : rd_d;
  assign lk_t = fwd_r ? row_t_r : rd_t;
  assign lk_s = fwd_r ? row_s_r : rd_s;

  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (lk_v[w] && (lk_t[w] == cur_tag)) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!lk_v[w]) begin
        inv_any = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // Memory port steering.
  always_comb begin
    tag_raddr = (st_r == ST_IDLE) ? set_of(in_data.address) : set_of(nxt_a);
    tag_we    = (st_r == ST_NEXT) ||
                ((st_r == ST_CLEAR) && (int'(clr_r) < SETS));
    tag_waddr = (st_r == ST_CLEAR) ? clr_r[SIW-1:0] : cur_set;
    tag_wdata = (st_r == ST_CLEAR) ? '0 : {row_v_r, row_d_r, row_t_r, row_s_r};

    dat_raddr = (st_r == ST_WB) ? slot_addr(cur_set, way_r, cnt_off)
                                : slot_addr(cur_set, way_r, cur_off);
    dat_we    = ((st_r == ST_FILL) && (cnt_r != '0)) ||
                ((st_r == ST_BYTE) && (req_r.op == OP_WRITE));
    dat_waddr = (st_r == ST_FILL) ? slot_addr(cur_set, way_r, cnt_prev)
                                  : slot_addr(cur_set, way_r, cur_off);
    dat_wdata = (st_r == ST_FILL) ? mem_rdata : req_r.write_data[{bi_r, 3'b000} +: 8];

    mem_raddr = line_addr(cur_tag, cur_set, cnt_off);
    mem_we    = (st_r == ST_CLEAR) || ((st_r == ST_WB) && (cnt_r != '0));
    mem_waddr = (st_r == ST_CLEAR) ? clr_r : line_addr(row_t_r[way_r], cur_set, cnt_prev);
    mem_wdata = (st_r == ST_CLEAR) ? 8'h00 : dat_rdata;
  end

  sac_ram #(.W(ROW_W), .DEPTH(SETS), .AW(SIW)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
    .raddr(tag_raddr), .rdata(tag_rdata)
  );

  sac_ram #(.W(8), .DEPTH(DATA_DEPTH), .AW(DA_W)) u_data_ram (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(dat_wdata),
    .raddr(dat_raddr), .rdata(dat_rdata)
  );

  sac_ram #(.W(8), .DEPTH(MEM_DEPTH), .AW(ADDR_BITS)) u_back_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR: begin
        if (clr_r == '1) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          st_nxt = (!size_ok || past_end) ? ST_DONE : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_any) st_nxt = ST_BYTE;
        else if (inv_any) st_nxt = ST_FILL;
        else st_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_r == WC_W'(WAYS)) st_nxt = row_d_r[way_r] ? ST_WB : ST_FILL;
      end
      ST_WB: begin
        if (cnt_r == (OFF_W+1)'(LINE_BYTES)) st_nxt = ST_FILL;
      end
      ST_FILL: begin
        if (cnt_r == (OFF_W+1)'(LINE_BYTES)) st_nxt = ST_BYTE;
      end
      ST_BYTE: begin
        st_nxt = (req_r.op == OP_WRITE) ? ST_NEXT : ST_BYTE_RD;
      end
      ST_BYTE_RD: st_nxt = ST_NEXT;
      ST_NEXT: begin
        if (last_byte) st_nxt = ST_DONE;
        else if (nxt_a[OFF_W-1:0] == '0) st_nxt = ST_LOOK;
        else st_nxt = ST_BYTE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= ST_CLEAR;
      clr_r         <= '0;
      fwd_r         <= 1'b0;
      use_ctr_r     <= '0;
      hit_tally_r   <= '0;
      miss_tally_r  <= '0;
      dirty_tally_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_valid_r && !out_stall && (st_r != ST_DONE)) out_valid_r <= 1'b0;
      case (st_r)
        ST_CLEAR: clr_r <= clr_r + ADDR_BITS'(1);
        ST_IDLE: begin
          if (in_valid) begin
            req_r   <= in_data;
            bi_r    <= '0;
            acc_h_r <= '0;
            acc_m_r <= '0;
            acc_w_r <= '0;
            fwd_r   <= 1'b0;
            rdata_r <= size_ok ? '0 : '1;
            if (!size_ok) begin
              status_r <= STAT_BAD_SIZE;
            end else if (past_end) begin
              status_r <= STAT_PAST_END;
            end else begin
              status_r <= STAT_OK;
            end
          end
        end
        ST_LOOK: begin
          row_v_r <= lk_v;
          row_d_r <= lk_d;
          row_t_r <= lk_t;
          // A hit takes a fresh stamp on its way.
          for (int w = 0; w < WAYS; w++) begin
            row_s_r[w] <= (hit_any && (hit_way == WAY_W'(w))) ? use_inc : lk_s[w];
          end
          cnt_r   <= '0;
          if (hit_any) begin
            way_r            <= hit_way;
            use_ctr_r        <= use_inc;
            hit_tally_r      <= hit_tally_r + TALLY_W'(1);
            acc_h_r          <= acc_h_r + 2'd1;
          end else begin
            miss_tally_r <= miss_tally_r + TALLY_W'(1);
            acc_m_r      <= acc_m_r + 2'd1;
            way_r        <= inv_any ? inv_way : '0;
            scan_r       <= WC_W'(1);
          end
        end
        ST_SCAN: begin
          if (scan_r == WC_W'(WAYS)) begin
            // Eviction takes a stamp of its own before the fill.
            use_ctr_r <= use_inc;
            cnt_r     <= '0;
            if (row_d_r[way_r]) begin
              dirty_tally_r <= dirty_tally_r + TALLY_W'(1);
              acc_w_r       <= acc_w_r + 2'd1;
            end
          end else begin
            if (row_s_r[scan_way] < row_s_r[way_r]) way_r <= scan_way;
            scan_r <= scan_r + WC_W'(1);
          end
        end
        ST_WB: begin
          cnt_r <= (cnt_r == (OFF_W+1)'(LINE_BYTES)) ? '0 : cnt_r + (OFF_W+1)'(1);
        end
        ST_FILL: begin
          cnt_r <= cnt_r + (OFF_W+1)'(1);
          if (cnt_r == (OFF_W+1)'(LINE_BYTES)) begin
            use_ctr_r      <= use_inc;
            row_v_r[way_r] <= 1'b1;
            row_d_r[way_r] <= 1'b0;
            row_t_r[way_r] <= cur_tag;
            row_s_r[way_r] <= use_inc;
          end
        end
        ST_BYTE: begin
          if (req_r.op == OP_WRITE) begin
            use_ctr_r      <= use_inc;
            row_d_r[way_r] <= 1'b1;
            row_s_r[way_r] <= use_inc;
          end
        end
        ST_BYTE_RD: rdata_r[{bi_r, 3'b000} +: 8] <= dat_rdata;
        ST_NEXT: begin
          fwd_r <= (set_of(nxt_a) == cur_set);
          if (!last_byte) bi_r <= bi_r + 2'd1;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r                   <= 1'b1;
            out_data_r.read_data          <= rdata_r;
            out_data_r.status             <= status_r;
            out_data_r.access_hits        <= acc_h_r;
            out_data_r.access_misses      <= acc_m_r;
            out_data_r.access_writebacks  <= acc_w_r;
            out_data_r.total_hits         <= hit_tally_r;
            out_data_r.total_misses       <= miss_tally_r;
            out_data_r.total_dirty_misses <= dirty_tally_r;
          end
        end
        default: clr_r <= clr_r;
      endcase
    end
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic rsp_err, rsp_looked, rsp_wb_ok;
  assign rsp_err    = (out_data.status != STAT_OK);
  assign rsp_looked = (out_data.access_hits != 2'd0) || (out_data.access_misses != 2'd0);
  assign rsp_wb_ok  = (out_data.access_writebacks <= out_data.access_misses);

  `SAC_ASSERT(a_err_no_lookup, out_valid && rsp_err |-> !rsp_looked, "error result shows lookups")
  `SAC_ASSERT(a_ok_looked_up, out_valid && !rsp_err |-> rsp_looked, "ok result without lookup")
  `SAC_ASSERT(a_wb_le_miss, out_valid |-> rsp_wb_ok, "write-back without miss")
  `SAC_ASSERT_NEXT(a_done_drives_out, (st_r == ST_DONE) && !out_stall, out_valid, "result held back")

endmodule
